[src/tdml_pkg.sv]
// Package with the character classes, token codes, scanner states and tables of the lexer.
`timescale 1ns / 1ps
package tdml_pkg;

  localparam int MAX_LEXEME_DEF = 32;
  localparam int VALUE_W = 31;
  localparam int KIND_W = 4;
  localparam int NUM_RWORDS = 4;
  localparam int RWORD_MAX = 8;

  typedef enum logic [3:0] {
    C_LETTER = 4'd0,
    C_DIGIT  = 4'd1,
    C_PLUS   = 4'd2,
    C_MINUS  = 4'd3,
    C_LPAREN = 4'd4,
    C_RPAREN = 4'd5,
    C_COMMA  = 4'd6,
    C_SEMI   = 4'd7,
    C_COLON  = 4'd8,
    C_EQUALS = 4'd9,
    C_EOF    = 4'd10,
    C_SPACE  = 4'd11,
    C_OTHER  = 4'd12
  } cls_t;

  typedef enum logic [KIND_W-1:0] {
    T_INICIO   = 4'd0,
    T_FIN      = 4'd1,
    T_LEER     = 4'd2,
    T_ESCRIBIR = 4'd3,
    T_ID       = 4'd4,
    T_CONST    = 4'd5,
    T_LPAREN   = 4'd6,
    T_RPAREN   = 4'd7,
    T_SEMI     = 4'd8,
    T_COMMA    = 4'd9,
    T_ASSIGN   = 4'd10,
    T_PLUS     = 4'd11,
    T_MINUS    = 4'd12,
    T_EOF      = 4'd13,
    T_ERROR    = 4'd14
  } tok_t;

  typedef enum logic [1:0] {
    S_START = 2'd0,
    S_IDENT = 2'd1,
    S_CONST = 2'd2,
    S_COLON = 2'd3
  } st_t;

  typedef struct packed {
    logic       emit;
    tok_t       kind;
    logic [1:0] len;
    st_t        st;
  } start_t;

  localparam logic [7:0] RWORD_CHARS [NUM_RWORDS][RWORD_MAX] = '{
    '{"i", "n", "i", "c", "i", "o", 8'h00, 8'h00},
    '{"f", "i", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "e", "e", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "s", "c", "r", "i", "b", "i", "r"}
  };

  localparam logic [3:0] RWORD_LEN [NUM_RWORDS] = '{4'd6, 4'd3, 4'd4, 4'd8};

  function automatic cls_t classify(input logic [7:0] c, input logic eof);
    cls_t r;
    r = C_OTHER;
    priority if (eof) r = C_EOF;
    else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) r = C_LETTER;
    else if (c >= 8'h30 && c <= 8'h39) r = C_DIGIT;
    else if (c == "+") r = C_PLUS;
    else if (c == "-") r = C_MINUS;
    else if (c == "(") r = C_LPAREN;
    else if (c == ")") r = C_RPAREN;
    else if (c == ",") r = C_COMMA;
    else if (c == ";") r = C_SEMI;
    else if (c == ":") r = C_COLON;
    else if (c == "=") r = C_EQUALS;
    else if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) r = C_SPACE;
    else r = C_OTHER;
    return r;
  endfunction

  // Action of the start state for every class except letters and digits.
  function automatic start_t start_step(input cls_t c);
    start_t r;
    r = '{emit: 1'b1, kind: T_ERROR, len: 2'd1, st: S_START};
    unique case (c)
      C_PLUS:   r.kind = T_PLUS;
      C_MINUS:  r.kind = T_MINUS;
      C_LPAREN: r.kind = T_LPAREN;
      C_RPAREN: r.kind = T_RPAREN;
      C_COMMA:  r.kind = T_COMMA;
      C_SEMI:   r.kind = T_SEMI;
      C_COLON: begin
        r.emit = 1'b0;
        r.st = S_COLON;
      end
      C_EOF: begin
        r.kind = T_EOF;
        r.len = 2'd0;
      end
      C_SPACE:  r.emit = 1'b0;
      default:  r.kind = T_ERROR;
    endcase
    return r;
  endfunction

endpackage

[src/table_driven_micro_lexer.sv]
// Top level of the table-driven micro-language lexer with its two-entry result buffer.
// A token is offered on the out_ channel in the cycle after its character is taken.
// Throughput: one character per cycle while out_ready is high; a character that ends a lexeme
// and also forms a token of its own yields two tokens and holds in_ready low while the
// two-entry result buffer drains.
// Reset: synchronous and active low; returns the scanner to the start state, empty buffer.
`timescale 1ns / 1ps
module table_driven_micro_lexer #(
  parameter int MAX_LEXEME = tdml_pkg::MAX_LEXEME_DEF,
  localparam int LEN_W = $clog2(MAX_LEXEME + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_ch,
  input  logic                         in_end_of_file,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tdml_pkg::KIND_W-1:0]  out_token_kind,
  output logic [tdml_pkg::VALUE_W-1:0] out_const_value,
  output logic [LEN_W-1:0]             out_lexeme_length,
  output logic                         out_too_long,
  output logic                         out_last
);
  import tdml_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LEXEME);
  localparam logic [VALUE_W+3:0] VALUE_MAX = {4'd0, {VALUE_W{1'b1}}};

  typedef struct packed {
    tok_t               kind;
    logic [VALUE_W-1:0] value;
    logic [LEN_W-1:0]   len;
    logic               too_long;
    logic               last;
  } res_t;

  st_t                     st_r, st_nxt;
  logic [LEN_W-1:0]        cnt_r, cnt_nxt;
  logic [NUM_RWORDS-1:0]   flags_r, flags_nxt;
  logic [VALUE_W-1:0]      acc_r, acc_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [1:0]              buf_cnt_r, buf_cnt_nxt;
  res_t                    slot0_r, slot0_nxt, slot1_r, slot1_nxt;

  cls_t                    cls;
  logic                    accept, pop;
  logic [LEN_W-1:0]        cnt_b;
  logic                    ovf_b;
  logic [NUM_RWORDS-1:0]   flags_upd;
  logic [VALUE_W+3:0]      mac;
  logic [VALUE_W-1:0]      acc_mac;
  tok_t                    id_kind;
  start_t                  sp;
  res_t                    rs0, rs1;
  logic [1:0]              n_res;

  assign cls = classify(in_ch, in_end_of_file);
  assign in_ready = (buf_cnt_r == 2'd0) || (buf_cnt_r == 2'd1 && out_ready);
  assign accept = in_valid && in_ready;
  assign out_valid = (buf_cnt_r != 2'd0);
  assign pop = out_valid && out_ready;

  assign cnt_b = (cnt_r < MAX_LEN) ? cnt_r + 1'b1 : cnt_r;
  assign ovf_b = ovf_r | (cnt_r >= MAX_LEN);

  always_comb begin
    for (int k = 0; k < NUM_RWORDS; k++) begin
      flags_upd[k] = flags_r[k] && (cnt_r < LEN_W'(RWORD_LEN[k])) &&
                     (in_ch == RWORD_CHARS[k][cnt_r[2:0]]);
    end
  end

  assign mac = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + (VALUE_W + 4)'(in_ch - 8'h30);
  assign acc_mac = (mac > VALUE_MAX) ? VALUE_MAX[VALUE_W-1:0] : mac[VALUE_W-1:0];

  always_comb begin
    priority if (ovf_r) id_kind = T_ID;
    else if (flags_r[0] && cnt_r == LEN_W'(RWORD_LEN[0])) id_kind = T_INICIO;
    else if (flags_r[1] && cnt_r == LEN_W'(RWORD_LEN[1])) id_kind = T_FIN;
    else if (flags_r[2] && cnt_r == LEN_W'(RWORD_LEN[2])) id_kind = T_LEER;
    else if (flags_r[3] && cnt_r == LEN_W'(RWORD_LEN[3])) id_kind = T_ESCRIBIR;
    else id_kind = T_ID;
  end

  assign sp = start_step(cls);

  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    flags_nxt = flags_r;
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    rs0 = '{kind: T_ERROR, value: '0, len: '0, too_long: 1'b0, last: 1'b0};
    rs1 = '{kind: sp.kind, value: '0, len: LEN_W'(sp.len), too_long: 1'b0, last: 1'b1};
    n_res = 2'd0;
    if (accept) begin
      unique case (st_r)
        S_START: begin
          if (cls == C_LETTER || cls == C_DIGIT) begin
            flags_nxt = flags_upd;
            cnt_nxt = cnt_b;
            ovf_nxt = ovf_b;
            if (cls == C_DIGIT) begin
              acc_nxt = acc_mac;
              st_nxt = S_CONST;
            end else begin
              st_nxt = S_IDENT;
            end
          end else begin
            rs0.kind = sp.kind;
            rs0.len = LEN_W'(sp.len);
            n_res = sp.emit ? 2'd1 : 2'd0;
            st_nxt = sp.st;
            cnt_nxt = (sp.st == S_COLON) ? LEN_W'(1) : '0;
          end
        end
        S_IDENT, S_CONST: begin
          if (cls == C_LETTER && st_r == S_IDENT || cls == C_DIGIT) begin
            flags_nxt = flags_upd;
            cnt_nxt = cnt_b;
            ovf_nxt = ovf_b;
            if (st_r == S_CONST) acc_nxt = acc_mac;
          end else begin
            st_nxt = S_START;
            cnt_nxt = '0;
            flags_nxt = '1;
            acc_nxt = '0;
            ovf_nxt = 1'b0;
            n_res = 2'd1;
            rs0.len = cnt_r;
            rs0.too_long = ovf_r;
            if (cls == C_LETTER) begin
              // A letter right after a digit ends the constant as an error.
              rs0.kind = T_ERROR;
              rs0.len = cnt_b;
              rs0.too_long = ovf_b;
            end else begin
              rs0.kind = (st_r == S_IDENT) ? id_kind : T_CONST;
              rs0.value = (st_r == S_IDENT) ? '0 : acc_r;
              if (cls != C_SPACE) begin
                n_res = sp.emit ? 2'd2 : 2'd1;
                st_nxt = sp.st;
                cnt_nxt = (sp.st == S_COLON) ? LEN_W'(1) : '0;
              end
            end
          end
        end
        S_COLON: begin
          n_res = 2'd1;
          if (cls == C_EQUALS) begin
            rs0.kind = T_ASSIGN;
            rs0.len = LEN_W'(2);
          end else begin
            rs0.kind = T_ERROR;
            rs0.len = (cls == C_SPACE) ? cnt_r : cnt_b;
            rs0.too_long = ovf_r;
          end
          st_nxt = S_START;
          cnt_nxt = '0;
          flags_nxt = '1;
          acc_nxt = '0;
          ovf_nxt = 1'b0;
        end
        default: st_nxt = S_START;
      endcase
    end
    rs0.last = (n_res == 2'd1);
  end

  always_comb begin
    buf_cnt_nxt = buf_cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (accept) begin
      buf_cnt_nxt = n_res;
      slot0_nxt = rs0;
      slot1_nxt = rs1;
    end else if (pop) begin
      buf_cnt_nxt = buf_cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_START;
      cnt_r <= '0;
      flags_r <= '1;
      acc_r <= '0;
      ovf_r <= 1'b0;
      buf_cnt_r <= 2'd0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      flags_r <= flags_nxt;
      acc_r <= acc_nxt;
      ovf_r <= ovf_nxt;
      buf_cnt_r <= buf_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  assign out_token_kind = slot0_r.kind;
  assign out_const_value = slot0_r.value;
  assign out_lexeme_length = slot0_r.len;
  assign out_too_long = slot0_r.too_long;
  assign out_last = slot0_r.last;

  // A token that is not the last of its transaction always has its partner buffered.
  a_partner_buffered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> (buf_cnt_r == 2'd2))
    else $error("non-final token without a buffered partner");

  // A transaction that yields two tokens shows the first one in the next cycle.
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && n_res == 2'd2) |=> (out_valid && !out_last))
    else $error("two-token transaction not presented in order");

  // A lexeme in progress has at least one character counted.
  a_lexeme_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_START) |-> (cnt_r != '0))
    else $error("scanner inside a lexeme with zero length");

  // The start state always carries cleared lexeme state.
  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_START) |-> (flags_r == '1 && acc_r == '0 && cnt_r == '0 && !ovf_r))
    else $error("start state with stale lexeme state");

endmodule
